### hw/rtl/tfs_pkg.sv
`timescale 1ns / 1ps

package tfs_pkg;

    localparam int COORD_WIDTH      = 32;
    localparam int NORMAL_FRAC_BITS = 15;

    localparam int EDGE_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = PROD_W;
    localparam int RED_W   = 31;
    localparam int SQ_W    = 2 * RED_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int NUM_W   = SQ_W + 2 * NORMAL_FRAC_BITS;
    localparam int LEN_W   = $clog2(MAG_W + 1);
    localparam int QUO_W   = 2 * NORMAL_FRAC_BITS + 1;
    localparam int ROOT_W  = NORMAL_FRAC_BITS + 1;
    localparam int DIV_STAGES  = QUO_W;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int ROOT_DEPTH  = DIV_STAGES + SQRT_STAGES;
    localparam int LANES   = 4;
    localparam int OUT_W   = 16;
    localparam int SHADE_W = 8;

    localparam logic [OUT_W-1:0] POS_MAX = 16'h7FFF;
    localparam logic [OUT_W-1:0] NEG_MIN = 16'h8000;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_x;
        logic signed [COORD_WIDTH-1:0] a_y;
        logic signed [COORD_WIDTH-1:0] a_z;
        logic signed [COORD_WIDTH-1:0] b_x;
        logic signed [COORD_WIDTH-1:0] b_y;
        logic signed [COORD_WIDTH-1:0] b_z;
        logic signed [COORD_WIDTH-1:0] c_x;
        logic signed [COORD_WIDTH-1:0] c_y;
        logic signed [COORD_WIDTH-1:0] c_z;
    } t_tri_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] unit_nx;
        logic signed [OUT_W-1:0] unit_ny;
        logic signed [OUT_W-1:0] unit_nz;
        logic [SHADE_W-1:0]      shade;
        logic                    degenerate;
    } t_tri_out;

    typedef struct packed {
        logic       valid;
        logic [2:0] neg;
        logic       degen;
    } t_side;

endpackage

### hw/rtl/triangle_flat_shade.sv
`timescale 1ns / 1ps

// Flat shading of one triangle per item.
// The input channel (i_valid, i_data, o_stall) takes the three vertices as signed
// Q16.16 coordinates. The output channel (o_valid, o_data, i_stall) gives the unit face
// normal in signed Q1.15, saturated at 0x7FFF just below plus one, the intensity floor(255*|nz|/|n|)
// and a flag for a triangle whose normal has zero length, which then reads as zero.
// Throughput is one item per clock cycle while the output is not stalled. An accepted
// item passes through the edge, cross product, scaling and squaring stages, then the
// pipelined restoring divider, the pipelined square root and one output register
// before the result appears on o_valid.
// The whole pipeline moves on one enable; it halts only when a result sits in the
// output register and i_stall is high, and o_stall is raised in exactly those
// cycles, so nothing is dropped or repeated and bubbles simply pass through.
// Reset clears all valid bits; no result is shown until a new item comes through.
module triangle_flat_shade (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  tfs_pkg::t_tri_in  i_data,
    output logic              o_stall,
    output logic              o_valid,
    output tfs_pkg::t_tri_out o_data,
    input  logic              i_stall
);

    localparam int EW = tfs_pkg::EDGE_W;
    localparam int PW = tfs_pkg::PROD_W;
    localparam int CW = tfs_pkg::CROSS_W;
    localparam int MW = tfs_pkg::MAG_W;
    localparam int RW = tfs_pkg::RED_W;
    localparam int SB = tfs_pkg::COORD_WIDTH - 1;

    logic en;

    logic                 r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;
    logic signed [EW-1:0] r_e [3];
    logic signed [EW-1:0] r_f [3];
    logic signed [PW-1:0] r_p [3];
    logic signed [PW-1:0] r_q [3];
    logic signed [CW-1:0] r_n [3];
    logic [MW-1:0]        r_mag4 [3];
    logic [MW-1:0]        r_mag5 [3];
    logic [2:0]           r_neg4, r_neg5, r_neg6, r_neg7, r_neg8;
    logic                 r_dg4, r_dg5, r_dg6, r_dg7, r_dg8;
    logic [tfs_pkg::LEN_W-1:0] r_shift;
    logic [tfs_pkg::LEN_W-1:0] n_shift;
    logic [RW-1:0]        r_m [3];
    logic [tfs_pkg::SQ_W-1:0]  r_sq [3];
    logic [tfs_pkg::SUM_W-1:0] r_sum;
    logic [tfs_pkg::NUM_W-1:0] r_num [tfs_pkg::LANES];
    logic [tfs_pkg::ROOT_W-1:0] root [tfs_pkg::LANES];

    tfs_pkg::t_side r_side [tfs_pkg::ROOT_DEPTH];
    logic              r_out_valid;
    tfs_pkg::t_tri_out r_out;
    tfs_pkg::t_tri_out n_out;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    always_comb begin
        n_shift = '0;
        for (int b = 0; b < MW; b++) begin
            if ((r_mag4[0][b] | r_mag4[1][b] | r_mag4[2][b]) && b >= RW) begin
                n_shift = tfs_pkg::LEN_W'(b + 1 - RW);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e[0] <= $signed({i_data.b_x[SB], i_data.b_x}) - $signed({i_data.a_x[SB], i_data.a_x});
            r_e[1] <= $signed({i_data.b_y[SB], i_data.b_y}) - $signed({i_data.a_y[SB], i_data.a_y});
            r_e[2] <= $signed({i_data.b_z[SB], i_data.b_z}) - $signed({i_data.a_z[SB], i_data.a_z});
            r_f[0] <= $signed({i_data.c_x[SB], i_data.c_x}) - $signed({i_data.a_x[SB], i_data.a_x});
            r_f[1] <= $signed({i_data.c_y[SB], i_data.c_y}) - $signed({i_data.a_y[SB], i_data.a_y});
            r_f[2] <= $signed({i_data.c_z[SB], i_data.c_z}) - $signed({i_data.a_z[SB], i_data.a_z});

            r_p[0] <= r_e[1] * r_f[2];
            r_q[0] <= r_e[2] * r_f[1];
            r_p[1] <= r_e[2] * r_f[0];
            r_q[1] <= r_e[0] * r_f[2];
            r_p[2] <= r_e[0] * r_f[1];
            r_q[2] <= r_e[1] * r_f[0];

            for (int i = 0; i < 3; i++) begin
                r_n[i] <= $signed({r_p[i][PW-1], r_p[i]}) - $signed({r_q[i][PW-1], r_q[i]});
            end

            for (int i = 0; i < 3; i++) begin
                r_neg4[i] <= r_n[i][CW-1];
                r_mag4[i] <= r_n[i][CW-1] ? MW'(-r_n[i]) : MW'(r_n[i]);
            end
            r_dg4 <= (r_n[0] == '0) && (r_n[1] == '0) && (r_n[2] == '0);

            r_mag5  <= r_mag4;
            r_shift <= n_shift;
            r_neg5  <= r_neg4;
            r_dg5   <= r_dg4;

            for (int i = 0; i < 3; i++) begin
                r_m[i] <= RW'(r_mag5[i] >> r_shift);
            end
            r_neg6 <= r_neg5;
            r_dg6  <= r_dg5;

            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_m[i] * r_m[i];
            end
            r_neg7 <= r_neg6;
            r_dg7  <= r_dg6;

            r_sum <= tfs_pkg::SUM_W'(r_sq[0]) + tfs_pkg::SUM_W'(r_sq[1])
                   + tfs_pkg::SUM_W'(r_sq[2]);
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= tfs_pkg::NUM_W'(r_sq[i]) << (2 * tfs_pkg::NORMAL_FRAC_BITS);
            end
            // 65025 is 2^16 - 2^9 + 1.
            r_num[3] <= (tfs_pkg::NUM_W'(r_sq[2]) << 16) - (tfs_pkg::NUM_W'(r_sq[2]) << 9)
                      + tfs_pkg::NUM_W'(r_sq[2]);
            r_neg8 <= r_neg7;
            r_dg8  <= r_dg7;
        end
    end

    for (genvar g = 0; g < tfs_pkg::LANES; g++) begin : g_lane
        tfs_root u_root (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_sum  (r_sum),
            .i_num  (r_num[g]),
            .o_root (root[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < tfs_pkg::ROOT_DEPTH; k++) begin
                r_side[k] <= '0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_side[0] <= '{valid: r_v8, neg: r_neg8, degen: r_dg8};
            for (int k = 1; k < tfs_pkg::ROOT_DEPTH; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_out_valid <= r_side[tfs_pkg::ROOT_DEPTH-1].valid;
        end
    end

    always_comb begin
        logic [tfs_pkg::OUT_W-1:0] comp [3];
        logic [tfs_pkg::OUT_W-1:0] mag;
        tfs_pkg::t_side            side;
        side = r_side[tfs_pkg::ROOT_DEPTH-1];
        for (int i = 0; i < 3; i++) begin
            mag = tfs_pkg::OUT_W'(root[i]);
            if (side.neg[i]) begin
                comp[i] = (mag >= tfs_pkg::NEG_MIN) ? tfs_pkg::NEG_MIN : -mag;
            end else begin
                comp[i] = (mag >= tfs_pkg::POS_MAX) ? tfs_pkg::POS_MAX : mag;
            end
        end
        n_out.unit_nx    = side.degen ? '0 : comp[0];
        n_out.unit_ny    = side.degen ? '0 : comp[1];
        n_out.unit_nz    = side.degen ? '0 : comp[2];
        n_out.shade      = side.degen ? '0 : tfs_pkg::SHADE_W'(root[3]);
        n_out.degenerate = side.degen;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

endmodule

### hw/rtl/tfs_root.sv
`timescale 1ns / 1ps

// One lane: pipelined restoring divide of num by sum, then a pipelined integer square root.
module tfs_root (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [tfs_pkg::SUM_W-1:0]        i_sum,
    input  logic [tfs_pkg::NUM_W-1:0]        i_num,
    output logic [tfs_pkg::ROOT_W-1:0]       o_root
);

    localparam int CMP_W = tfs_pkg::SUM_W + tfs_pkg::QUO_W;

    logic [tfs_pkg::NUM_W-1:0]  r_rem [tfs_pkg::DIV_STAGES];
    logic [tfs_pkg::SUM_W-1:0]  r_den [tfs_pkg::DIV_STAGES];
    logic [tfs_pkg::QUO_W-1:0]  r_quo [tfs_pkg::DIV_STAGES];
    logic [tfs_pkg::NUM_W-1:0]  n_rem [tfs_pkg::DIV_STAGES];
    logic [tfs_pkg::QUO_W-1:0]  n_quo [tfs_pkg::DIV_STAGES];

    logic [tfs_pkg::QUO_W-1:0]  r_val [tfs_pkg::SQRT_STAGES];
    logic [tfs_pkg::ROOT_W-1:0] r_rt  [tfs_pkg::SQRT_STAGES];
    logic [tfs_pkg::ROOT_W-1:0] n_rt  [tfs_pkg::SQRT_STAGES];

    always_comb begin
        logic [tfs_pkg::NUM_W-1:0] rem_in;
        logic [tfs_pkg::SUM_W-1:0] den_in;
        logic [tfs_pkg::QUO_W-1:0] quo_in;
        logic [CMP_W-1:0]          trial;
        for (int k = 0; k < tfs_pkg::DIV_STAGES; k++) begin
            rem_in = (k == 0) ? i_num : r_rem[(k == 0) ? 0 : k - 1];
            den_in = (k == 0) ? i_sum : r_den[(k == 0) ? 0 : k - 1];
            quo_in = (k == 0) ? '0 : r_quo[(k == 0) ? 0 : k - 1];
            trial  = CMP_W'(den_in) << (tfs_pkg::DIV_STAGES - 1 - k);
            if (trial <= CMP_W'(rem_in)) begin
                n_rem[k] = rem_in - tfs_pkg::NUM_W'(trial);
                n_quo[k] = quo_in | (tfs_pkg::QUO_W'(1) << (tfs_pkg::DIV_STAGES - 1 - k));
            end else begin
                n_rem[k] = rem_in;
                n_quo[k] = quo_in;
            end
        end
    end

    always_comb begin
        logic [tfs_pkg::QUO_W-1:0]    val_in;
        logic [tfs_pkg::ROOT_W-1:0]   rt_in;
        logic [tfs_pkg::ROOT_W-1:0]   cand;
        logic [2*tfs_pkg::ROOT_W-1:0] cand_sq;
        for (int k = 0; k < tfs_pkg::SQRT_STAGES; k++) begin
            val_in  = (k == 0) ? r_quo[tfs_pkg::DIV_STAGES-1] : r_val[(k == 0) ? 0 : k - 1];
            rt_in   = (k == 0) ? '0 : r_rt[(k == 0) ? 0 : k - 1];
            cand    = rt_in | (tfs_pkg::ROOT_W'(1) << (tfs_pkg::SQRT_STAGES - 1 - k));
            cand_sq = cand * cand;
            n_rt[k] = (cand_sq <= (2*tfs_pkg::ROOT_W)'(val_in)) ? cand : rt_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < tfs_pkg::DIV_STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= (k == 0) ? i_sum : r_den[(k == 0) ? 0 : k - 1];
            end
            for (int k = 0; k < tfs_pkg::SQRT_STAGES; k++) begin
                r_rt[k]  <= n_rt[k];
                r_val[k] <= (k == 0) ? r_quo[tfs_pkg::DIV_STAGES-1] : r_val[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign o_root = r_rt[tfs_pkg::SQRT_STAGES-1];

endmodule

### hw/rtl/tfs_checker.sv
`timescale 1ns / 1ps

module tfs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_stall,
    input logic              o_stall,
    input logic              o_valid,
    input tfs_pkg::t_tri_out o_data
);

    // The input side is held back only while a result waits on a stalled output.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not match a waiting result");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.degenerate) |-> (o_data.unit_nx == '0 && o_data.unit_ny == '0
            && o_data.unit_nz == '0 && o_data.shade == '0))
        else $error("degenerate item carries a nonzero normal or shade");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed or vanished");

endmodule

bind triangle_flat_shade tfs_checker u_tfs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_stall (i_stall),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_data  (o_data)
);
